### rtl/hrbt_pkg.sv
// Shared types and constants of the HTTP request byte tokenizer.
package hrbt_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [3:0] {
        CLS_DELIM  = 4'd0,
        CLS_METHOD = 4'd1,
        CLS_PATH   = 4'd2,
        CLS_QNAME  = 4'd3,
        CLS_QVALUE = 4'd4,
        CLS_FRAG   = 4'd5,
        CLS_VER    = 4'd6,
        CLS_HNAME  = 4'd7,
        CLS_HVALUE = 4'd8,
        CLS_GARB   = 4'd9
    } byte_class_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NO_LF     = 3'd1,
        ERR_SHORT     = 3'd2,
        ERR_NO_CR     = 3'd3,
        ERR_MISSING   = 3'd4,
        ERR_EMPTY_URI = 3'd5,
        ERR_ORDER     = 3'd6
    } error_code_t;

    localparam logic [1:0] SEC_LINE = 2'd0;
    localparam logic [1:0] SEC_HDR  = 2'd1;
    localparam logic [1:0] SEC_REST = 2'd2;

    localparam logic [1:0] FLD_METHOD = 2'd0;
    localparam logic [1:0] FLD_URI    = 2'd1;
    localparam logic [1:0] FLD_VER    = 2'd2;

    localparam logic [1:0] URI_PATH  = 2'd0;
    localparam logic [1:0] URI_QUERY = 2'd1;
    localparam logic [1:0] URI_FRAG  = 2'd2;

    localparam logic [1:0] PH_NAME  = 2'd0;
    localparam logic [1:0] PH_SKIP  = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    localparam logic [2:0] HM_FULL  = 3'd4;
    localparam logic [2:0] HM_NONE  = 3'd5;
    localparam logic [2:0] HM_VALUE = 3'd6;

    typedef struct packed {
        logic [7:0]  data;
        byte_class_t cls;
        logic        start;
        logic        host;
        error_code_t err;
        logic        eom;
    } result_t;

    // Up to two results per request, compacted so that slot a is used first.
    typedef struct packed {
        logic    wr_a;
        logic    wr_b;
        result_t a;
        result_t b;
    } res_push_t;

    function automatic logic [7:0] host_char(input logic [1:0] idx);
        case (idx)
            2'd0:    host_char = 8'h48;
            2'd1:    host_char = 8'h6F;
            2'd2:    host_char = 8'h73;
            default: host_char = 8'h74;
        endcase
    endfunction

endpackage

### rtl/http_request_byte_tokenizer.sv
// Top level of the HTTP request byte tokenizer.
//   Channel   Direction  Handshake     Payload
//   input     in         push / full   data_byte, last_byte
//   result    out        pop / empty   out_byte, byte_class, token_start, host_value,
//                                      error_code, end_of_message
// One byte is taken every cycle while full is low; its result leaves with the next
// byte (both on the last), classified in that cycle, then kept in the four-entry queue.
// full rises when fewer than two queue entries are free, since one request may
// give two results. Reset clears the parse state and empties the queue.
module http_request_byte_tokenizer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic [3:0] byte_class,
    output logic       token_start,
    output logic       host_value,
    output logic [2:0] error_code,
    output logic       end_of_message
);
    import hrbt_pkg::*;

    res_push_t res;
    result_t   head;
    logic      take;

    assign take = push && !full;

    hrbt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .res       (res)
    );

    hrbt_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .res   (res),
        .pop   (pop),
        .full  (full),
        .empty (empty),
        .head  (head)
    );

    assign out_byte       = head.data;
    assign byte_class     = head.cls;
    assign token_start    = head.start;
    assign host_value     = head.host;
    assign error_code     = head.err;
    assign end_of_message = head.eom;

endmodule

### rtl/hrbt_front.sv
// Front part: holds one byte, classifies it against the next one and tracks parse state.
module hrbt_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output hrbt_pkg::res_push_t res
);
    import hrbt_pkg::*;

    typedef struct packed {
        logic [1:0]  section;
        logic [1:0]  line_field;
        logic [1:0]  uri_part;
        logic [1:0]  pair_phase;
        logic [1:0]  line_length;
        logic        token_nonempty;
        logic [2:0]  host_match;
        error_code_t sticky_error;
        logic        lf_expected;
    } pstate_t;

    typedef struct packed {
        pstate_t     st;
        byte_class_t cls;
        logic        ts;
        logic        hv;
    } cls_res_t;

    function automatic cls_res_t classify(input pstate_t s, input logic [7:0] b,
                                          input logic next_lf);
        cls_res_t r;
        r.st  = s;
        r.cls = CLS_DELIM;
        r.ts  = 1'b0;
        r.hv  = 1'b0;
        if (s.sticky_error != ERR_NONE) begin
            r.cls = CLS_GARB;
            return r;
        end
        if (s.lf_expected) begin
            r.st.lf_expected = 1'b0;
            if (b == CH_LF) begin
                r.st.line_length = 2'd0;
                return r;
            end
        end
        if (r.st.section >= SEC_REST) begin
            r.ts = ~r.st.token_nonempty;
            r.st.token_nonempty = 1'b1;
            r.cls = CLS_GARB;
            return r;
        end
        if (b == CH_LF) begin
            if (r.st.section == SEC_LINE) begin
                r.st.sticky_error = (r.st.line_length < 2'd2) ? ERR_SHORT : ERR_NO_CR;
                r.cls = CLS_GARB;
            end else if (r.st.line_length >= 2'd2) begin
                r.st.sticky_error = ERR_NO_CR;
                r.cls = CLS_GARB;
            end else begin
                r.st.section = SEC_REST;
                r.st.token_nonempty = 1'b0;
                r.st.line_length = 2'd0;
            end
            return r;
        end
        if (next_lf && r.st.line_length == 2'd0) begin
            if (r.st.section == SEC_LINE) begin
                r.st.sticky_error = ERR_SHORT;
                r.cls = CLS_GARB;
            end else begin
                r.st.section = SEC_REST;
                r.st.token_nonempty = 1'b0;
                r.st.lf_expected = 1'b1;
            end
            return r;
        end
        if (next_lf && b == CH_CR) begin
            if (r.st.section == SEC_LINE) begin
                if (r.st.line_field != FLD_VER || !r.st.token_nonempty) begin
                    r.st.sticky_error = ERR_MISSING;
                    r.cls = CLS_GARB;
                    return r;
                end
                r.st.section = SEC_HDR;
            end
            r.st.pair_phase = PH_NAME;
            r.st.host_match = 3'd0;
            r.st.token_nonempty = 1'b0;
            r.st.lf_expected = 1'b1;
            return r;
        end
        if (r.st.line_length < 2'd2) begin
            r.st.line_length = r.st.line_length + 2'd1;
        end
        // Line content. Delimiters leave the class at its default.
        if (r.st.section == SEC_LINE) begin
            if (r.st.line_field == FLD_METHOD) begin
                if (b != CH_SP) begin
                    r.cls = CLS_METHOD;
                end else if (!r.st.token_nonempty) begin
                    r.st.sticky_error = ERR_MISSING;
                    r.cls = CLS_GARB;
                    return r;
                end else begin
                    r.st.line_field = FLD_URI;
                    r.st.uri_part = URI_PATH;
                    r.st.pair_phase = PH_NAME;
                    r.st.token_nonempty = 1'b0;
                    return r;
                end
            end else if (r.st.line_field == FLD_URI) begin
                if (b == CH_SP) begin
                    if (r.st.uri_part == URI_PATH && !r.st.token_nonempty) begin
                        r.st.sticky_error = ERR_MISSING;
                        r.cls = CLS_GARB;
                    end else begin
                        r.st.line_field = FLD_VER;
                        r.st.token_nonempty = 1'b0;
                    end
                    return r;
                end
                if (r.st.uri_part == URI_PATH) begin
                    if (b == CH_QUEST || b == CH_HASH) begin
                        if (!r.st.token_nonempty) begin
                            r.st.sticky_error = ERR_EMPTY_URI;
                            r.cls = CLS_GARB;
                        end else begin
                            r.st.uri_part = (b == CH_QUEST) ? URI_QUERY : URI_FRAG;
                            r.st.pair_phase = PH_NAME;
                            r.st.token_nonempty = 1'b0;
                        end
                        return r;
                    end
                    r.cls = CLS_PATH;
                end else if (r.st.uri_part == URI_QUERY) begin
                    if (b == CH_QUEST) begin
                        r.st.sticky_error = ERR_ORDER;
                        r.cls = CLS_GARB;
                        return r;
                    end
                    if (b == CH_HASH) begin
                        r.st.uri_part = URI_FRAG;
                        r.st.token_nonempty = 1'b0;
                        return r;
                    end
                    if (b == CH_AMP) begin
                        r.st.pair_phase = PH_NAME;
                        r.st.token_nonempty = 1'b0;
                        return r;
                    end
                    if (b == CH_EQ && r.st.pair_phase == PH_NAME) begin
                        r.st.pair_phase = PH_SKIP;
                        r.st.token_nonempty = 1'b0;
                        return r;
                    end
                    r.cls = (r.st.pair_phase != PH_NAME) ? CLS_QVALUE : CLS_QNAME;
                end else begin
                    if (b == CH_QUEST) begin
                        r.st.sticky_error = ERR_ORDER;
                        r.cls = CLS_GARB;
                        return r;
                    end
                    r.cls = CLS_FRAG;
                end
            end else begin
                r.cls = CLS_VER;
            end
        end else begin
            if (r.st.pair_phase == PH_NAME) begin
                if (b == CH_COLON) begin
                    r.st.host_match = (r.st.host_match == HM_FULL) ? HM_VALUE : HM_NONE;
                    r.st.pair_phase = PH_SKIP;
                    r.st.token_nonempty = 1'b0;
                    return r;
                end
                if (r.st.host_match < HM_FULL && b == host_char(r.st.host_match[1:0])) begin
                    r.st.host_match = r.st.host_match + 3'd1;
                end else begin
                    r.st.host_match = HM_NONE;
                end
                r.cls = CLS_HNAME;
            end else if (r.st.pair_phase == PH_SKIP) begin
                r.st.pair_phase = PH_VALUE;
                r.st.token_nonempty = 1'b0;
                return r;
            end else begin
                r.hv = (r.st.host_match == HM_VALUE);
                r.cls = CLS_HVALUE;
            end
        end
        r.ts = ~r.st.token_nonempty;
        r.st.token_nonempty = 1'b1;
        return r;
    endfunction

    pstate_t    st_reg, st_next;
    logic [7:0] held_reg, held_next;
    logic       held_valid_reg, held_valid_next;

    cls_res_t r0, r1;
    pstate_t  st1;
    logic     b_lf, in_line;
    result_t  res0, res1;

    always_comb
    begin
        b_lf    = (data_byte == CH_LF);
        in_line = last_byte && st_reg.section == SEC_HDR &&
                  st_reg.sticky_error == ERR_NONE && !b_lf && held_reg != CH_LF;
        r0 = classify(st_reg, held_reg, b_lf);
        st1 = held_valid_reg ? r0.st : st_reg;

        res0.data  = held_reg;
        res0.cls   = in_line ? CLS_GARB : r0.cls;
        res0.start = in_line ? 1'b1 : r0.ts;
        res0.host  = in_line ? 1'b0 : r0.hv;
        res0.err   = r0.st.sticky_error;
        res0.eom   = 1'b0;

        r1 = classify(st1, data_byte, 1'b0);
        res1.data = data_byte;
        res1.eom  = 1'b1;
        if (st1.section == SEC_HDR && st1.sticky_error == ERR_NONE && !b_lf) begin
            // An unterminated last header line turns into garbage.
            res1.cls   = CLS_GARB;
            res1.start = ~(held_valid_reg & in_line);
            res1.host  = 1'b0;
            res1.err   = st1.sticky_error;
        end else if (r1.st.sticky_error == ERR_NONE && r1.st.section == SEC_LINE) begin
            res1.cls   = CLS_GARB;
            res1.start = 1'b0;
            res1.host  = 1'b0;
            res1.err   = ERR_NO_LF;
        end else begin
            res1.cls   = r1.cls;
            res1.start = r1.ts;
            res1.host  = r1.hv;
            res1.err   = r1.st.sticky_error;
        end

        res.wr_a = take && (held_valid_reg || last_byte);
        res.wr_b = take && held_valid_reg && last_byte;
        res.a    = held_valid_reg ? res0 : res1;
        res.b    = res1;

        st_next         = st_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        if (take) begin
            if (last_byte) begin
                st_next         = '0;
                held_next       = 8'h00;
                held_valid_next = 1'b0;
            end else begin
                st_next         = st1;
                held_next       = data_byte;
                held_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= '0;
            held_reg       <= 8'h00;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

### rtl/hrbt_back.sv
// Back part: four-entry result queue taking up to two results a cycle, one out a cycle.
module hrbt_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  hrbt_pkg::res_push_t res,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output hrbt_pkg::result_t   head
);
    import hrbt_pkg::*;

    result_t    mem [4];
    logic [1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       do_pop;

    always_comb
    begin
        empty    = (cnt_reg == 3'd0);
        full     = (cnt_reg > 3'd2);
        head     = mem[rd_reg];
        do_pop   = pop && !empty;
        wr_next  = wr_reg + {1'b0, res.wr_a} + {1'b0, res.wr_b};
        rd_next  = rd_reg + {1'b0, do_pop};
        cnt_next = cnt_reg + {2'b00, res.wr_a} + {2'b00, res.wr_b} - {2'b00, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (res.wr_a)
        begin
            mem[wr_reg] <= res.a;
        end
        if (res.wr_b)
        begin
            mem[wr_reg + 2'd1] <= res.b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
